>>> sv/capture_channel_sequencer_assert.svh
// assertion macros for the capture channel sequencer
// expects clk and arst_n in the scope where the macros are used
`ifndef CAPTURE_CHANNEL_SEQUENCER_ASSERT_SVH
`define CAPTURE_CHANNEL_SEQUENCER_ASSERT_SVH

// cond implies prop in the same cycle
`define CCS_ASSERT_IMPLY(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("same-cycle implication failed");

// cond implies prop in the next cycle
`define CCS_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("next-cycle implication failed");

// cond never holds
`define CCS_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> sv/ccs_pkg.sv
// shared types and codes of the capture channel sequencer
// no dependencies
package ccs_pkg;

	// item modes
	localparam logic [1:0] MODE_CAPTURE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_TABLE   = 2'd2;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_ACK      = 3'd0;
	localparam logic [2:0] ST_QUIET    = 3'd1;
	localparam logic [2:0] ST_CAPTURED = 3'd2;
	localparam logic [2:0] ST_BUSY     = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_WRITTEN  = 3'd5;

	// configuration register indexes
	localparam logic CFG_ENABLE_MASK     = 1'b0;
	localparam logic CFG_INVALID_CHANNEL = 1'b1;

	localparam logic [15:0] SKIP_MASK     = 16'hFFFF;
	localparam logic [7:0]  INVALID_RESET = 8'hFF;

	// classification made by the front end
	typedef enum logic [2:0] {
		KIND_OUT_OF_RANGE,
		KIND_UNMASKED,
		KIND_CAPTURE,
		KIND_RELEASE,
		KIND_TABLE
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WRAP,
		BK_LOOKUP,
		BK_EXEC
	} back_state_t;

	// classified item held in the queue
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  path;
		logic        even;
		logic        loss;
		logic [2:0]  bslot;
		logic [3:0]  tslot;
		logic [7:0]  tval;
		logic [4:0]  tsize;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  filled_buffer;
		logic [2:0]  next_target;
		logic [7:0]  captured_channel;
		logic        field_flag;
		logic        loss_flag;
		logic [15:0] skip_word;
		logic        advanced;
		logic        notify;
	} res_t;

endpackage

>>> sv/capture_channel_sequencer.sv
// an accepted item is queued, taken from the queue in the back end idle step and passed
// through the lookup and execute steps, after which the result strobe is registered;
// the back end takes one item at a time, and a capture on an even field whose position
// lies beyond a shortened table also passes through the iterative remainder unit
// two items queue ahead of the back end, busy is high while both entries are taken
// reset: asynchronous, clears all control state at once, lock rows read as free until written
`include "capture_channel_sequencer_assert.svh"

module capture_channel_sequencer #(
	parameter int NUM_PATHS   = 16,
	parameter int RING_DEPTH  = 8,
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [3:0]  path,
	input  logic        field_even,
	input  logic        video_loss,
	input  logic [2:0]  buffer_slot,
	input  logic [3:0]  table_slot,
	input  logic [7:0]  table_value,
	input  logic [4:0]  table_size,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [2:0]  filled_buffer,
	output logic [2:0]  next_target,
	output logic [7:0]  captured_channel,
	output logic        field_flag,
	output logic        loss_flag,
	output logic [15:0] skip_word,
	output logic        advanced,
	output logic        notify
);

	ccs_pkg::q_status_t q_stat;
	ccs_pkg::cmd_t      push_cmd;
	ccs_pkg::cmd_t      head;
	ccs_pkg::res_t      res;
	logic               push;
	logic               pop;
	logic [7:0]         invalid_channel;

	// item acceptance and classification
	ccs_front #(
		.NUM_PATHS (NUM_PATHS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.mode            (mode),
		.path            (path),
		.field_even      (field_even),
		.video_loss      (video_loss),
		.buffer_slot     (buffer_slot),
		.table_slot      (table_slot),
		.table_value     (table_value),
		.table_size      (table_size),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.q_stat          (q_stat),
		.busy            (busy),
		.push            (push),
		.cmd             (push_cmd),
		.invalid_channel (invalid_channel)
	);

	// decoupling queue
	ccs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// state update and result
	ccs_back #(
		.NUM_PATHS   (NUM_PATHS),
		.RING_DEPTH  (RING_DEPTH),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_stat          (q_stat),
		.invalid_channel (invalid_channel),
		.pop             (pop),
		.done            (done),
		.res             (res)
	);

	// result fields
	assign status           = res.status;
	assign filled_buffer    = res.filled_buffer;
	assign next_target      = res.next_target;
	assign captured_channel = res.captured_channel;
	assign field_flag       = res.field_flag;
	assign loss_flag        = res.loss_flag;
	assign skip_word        = res.skip_word;
	assign advanced         = res.advanced;
	assign notify           = res.notify;

	// checks
	`CCS_ASSERT_NEXT(a_push_lands, start && !busy && (mode != ccs_pkg::MODE_UNUSED), !q_stat.empty)
	`CCS_ASSERT_NEXT(a_strobe_single, done, !done)
	`CCS_ASSERT_IMPLY(a_notify_captured, done && notify, status == ccs_pkg::ST_CAPTURED)
	`CCS_ASSERT_NEVER(a_queue_flags, q_stat.full && q_stat.empty)

endmodule

>>> sv/ccs_front.sv
// front end: configuration registers, item acceptance and classification
// depends on ccs_pkg
module ccs_front #(
	parameter int NUM_PATHS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          mode,
	input  logic [3:0]          path,
	input  logic                field_even,
	input  logic                video_loss,
	input  logic [2:0]          buffer_slot,
	input  logic [3:0]          table_slot,
	input  logic [7:0]          table_value,
	input  logic [4:0]          table_size,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  ccs_pkg::q_status_t  q_stat,
	output logic                busy,
	output logic                push,
	output ccs_pkg::cmd_t       cmd,
	output logic [7:0]          invalid_channel
);

	logic [15:0] mask_q;
	logic [7:0]  invalid_q;
	logic        path_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			invalid_q <= ccs_pkg::INVALID_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ccs_pkg::CFG_ENABLE_MASK:     mask_q    <= cfg_data;
				ccs_pkg::CFG_INVALID_CHANNEL: invalid_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign invalid_channel = invalid_q;

	// accept while the queue has room, unused mode is dropped here
	assign busy    = q_stat.full;
	assign push    = start && !q_stat.full && (mode != ccs_pkg::MODE_UNUSED);
	assign path_ok = ({1'b0, path} < 5'(NUM_PATHS));

	// classify the item
	always_comb begin
		cmd       = '0;
		cmd.path  = path;
		cmd.even  = field_even;
		cmd.loss  = video_loss;
		cmd.bslot = buffer_slot;
		cmd.tslot = table_slot;
		cmd.tval  = table_value;
		cmd.tsize = table_size;
		cmd.kind  = ccs_pkg::KIND_OUT_OF_RANGE;
		unique case (mode)
			ccs_pkg::MODE_CAPTURE: begin
				if (path_ok)
					cmd.kind = mask_q[path] ? ccs_pkg::KIND_CAPTURE : ccs_pkg::KIND_UNMASKED;
			end
			ccs_pkg::MODE_RELEASE: begin
				if (path_ok)
					cmd.kind = ccs_pkg::KIND_RELEASE;
			end
			ccs_pkg::MODE_TABLE: begin
				if (path_ok)
					cmd.kind = ccs_pkg::KIND_TABLE;
			end
			default: ;
		endcase
	end

endmodule

>>> sv/ccs_queue.sv
// two-entry queue of classified items between front and back end
// depends on ccs_pkg
module ccs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ccs_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output ccs_pkg::cmd_t       head,
	output ccs_pkg::q_status_t  q_stat
);

	ccs_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> sv/ccs_back.sv
// back end: per-path tables, buffer ring, lock rows and skip bits
// depends on ccs_pkg, fed by ccs_queue
module ccs_back #(
	parameter int NUM_PATHS   = 16,
	parameter int RING_DEPTH  = 8,
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccs_pkg::cmd_t       head,
	input  ccs_pkg::q_status_t  q_stat,
	input  logic [7:0]          invalid_channel,
	output logic                pop,
	output logic                done,
	output ccs_pkg::res_t       res
);

	localparam int PIW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int TIW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW  = $clog2(TABLE_DEPTH + 1);
	localparam int KCW = (LW > 1) ? $clog2(LW) : 1;
	localparam int DW  = 2 * LW;
	localparam int RIW = $clog2(RING_DEPTH);
	localparam int AW  = PIW + TIW;

	ccs_pkg::back_state_t state_q, state_d;
	ccs_pkg::cmd_t        cmd_q;

	logic [LW-1:0]         length_q   [NUM_PATHS];
	logic [TIW-1:0]        position_q [NUM_PATHS];
	logic [RIW-1:0]        ring_q     [NUM_PATHS];
	logic [NUM_PATHS-1:0]  row_valid_q;
	logic [NUM_PATHS-1:0]  skip_q;

	logic [RING_DEPTH-1:0] lock_mem [NUM_PATHS];
	logic [7:0]            chan_mem [2**AW];
	logic [RING_DEPTH-1:0] lock_row_q;
	logic [7:0]            rd_cur_q;
	logic [7:0]            rd_nxt_q;

	logic [TIW-1:0]        nxt_q;
	logic [LW-1:0]         rem_q;
	logic [KCW-1:0]        k_q;

	ccs_pkg::res_t         res_q;
	logic                  done_q;

	// head lookahead for the next table position
	logic [PIW-1:0]        hp;
	logic [LW-1:0]         h_len;
	logic [LW-1:0]         h_inc;
	logic                  wrap_needed;

	assign hp          = head.path[PIW-1:0];
	assign h_len       = length_q[hp];
	assign h_inc       = LW'(position_q[hp]) + LW'(1);
	assign wrap_needed = (head.kind == ccs_pkg::KIND_CAPTURE) && head.even && (h_inc > h_len);

	// remainder step: one quotient bit per cycle
	logic [PIW-1:0]        p;
	logic [DW-1:0]         dsh;
	logic [LW-1:0]         rem_step;

	assign p        = cmd_q.path[PIW-1:0];
	assign dsh      = DW'(length_q[p]) << k_q;
	assign rem_step = (DW'(rem_q) >= dsh) ? (rem_q - LW'(dsh)) : rem_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ccs_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	// next state and pop
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			ccs_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = wrap_needed ? ccs_pkg::BK_WRAP : ccs_pkg::BK_LOOKUP;
				end
			end
			ccs_pkg::BK_WRAP: begin
				if (k_q == '0)
					state_d = ccs_pkg::BK_LOOKUP;
			end
			ccs_pkg::BK_LOOKUP: state_d = ccs_pkg::BK_EXEC;
			ccs_pkg::BK_EXEC:   state_d = ccs_pkg::BK_IDLE;
			default:            state_d = ccs_pkg::BK_IDLE;
		endcase
	end

	// command capture and next position
	always_ff @(posedge clk) begin
		if (state_q == ccs_pkg::BK_IDLE && !q_stat.empty) begin
			cmd_q <= head;
			rem_q <= h_inc;
			k_q   <= KCW'(LW - 1);
			nxt_q <= (h_inc == h_len) ? '0 : TIW'(h_inc);
		end else if (state_q == ccs_pkg::BK_WRAP) begin
			rem_q <= rem_step;
			k_q   <= k_q - KCW'(1);
			if (k_q == '0)
				nxt_q <= TIW'(rem_step);
		end
	end

	// execute step datapath
	logic [RIW-1:0]        ridx;
	logic [RIW-1:0]        ring_inc;
	logic [RIW-1:0]        ring_new;
	logic [RING_DEPTH-1:0] row;
	logic                  quiet;
	logic                  exec;
	logic                  lock_we;
	logic [RING_DEPTH-1:0] lock_wdata;
	logic                  chan_we;
	logic                  len_we;
	logic [LW-1:0]         len_new;
	logic                  pos_we;
	logic                  ring_we;
	logic [NUM_PATHS-1:0]  skip_next;
	ccs_pkg::res_t         res_d;

	assign exec     = (state_q == ccs_pkg::BK_EXEC);
	assign ridx     = ring_q[p];
	assign ring_inc = (ridx == RIW'(RING_DEPTH - 1)) ? '0 : ridx + RIW'(1);
	assign row      = row_valid_q[p] ? lock_row_q : '0;
	assign quiet    = (rd_cur_q == invalid_channel) || (!cmd_q.loss && skip_q[p]);

	always_comb begin
		res_d      = '0;
		ring_new   = ridx;
		ring_we    = 1'b0;
		lock_we    = 1'b0;
		lock_wdata = row;
		chan_we    = 1'b0;
		len_we     = 1'b0;
		len_new    = LW'(1);
		pos_we     = 1'b0;
		skip_next  = skip_q;
		unique case (cmd_q.kind)
			ccs_pkg::KIND_OUT_OF_RANGE: res_d.status = ccs_pkg::ST_ACK;
			ccs_pkg::KIND_UNMASKED:     res_d.status = ccs_pkg::ST_ACK;
			ccs_pkg::KIND_CAPTURE: begin
				res_d.captured_channel = rd_cur_q;
				res_d.field_flag       = cmd_q.even;
				res_d.loss_flag        = cmd_q.loss;
				if (quiet) begin
					res_d.status = ccs_pkg::ST_QUIET;
				end else if (!row[ridx]) begin
					lock_we             = 1'b1;
					lock_wdata[ridx]    = 1'b1;
					ring_we             = 1'b1;
					ring_new            = ring_inc;
					res_d.filled_buffer = 3'(ridx);
					res_d.status        = ccs_pkg::ST_CAPTURED;
					res_d.notify        = 1'b1;
				end else begin
					res_d.status = ccs_pkg::ST_BUSY;
				end
				// even field moves the table on and rearms the skip bit
				if (cmd_q.even) begin
					pos_we         = 1'b1;
					skip_next[p]   = (rd_nxt_q == invalid_channel) || cmd_q.loss;
					res_d.advanced = 1'b1;
				end
			end
			ccs_pkg::KIND_RELEASE: begin
				if (32'(cmd_q.bslot) < 32'(RING_DEPTH)) begin
					lock_we                    = 1'b1;
					lock_wdata[RIW'(cmd_q.bslot)] = 1'b0;
				end
				res_d.status = ccs_pkg::ST_RELEASED;
			end
			ccs_pkg::KIND_TABLE: begin
				chan_we = (32'(cmd_q.tslot) < 32'(TABLE_DEPTH));
				len_we  = 1'b1;
				if (cmd_q.tsize == '0)
					len_new = LW'(1);
				else if (32'(cmd_q.tsize) > 32'(TABLE_DEPTH))
					len_new = LW'(TABLE_DEPTH);
				else
					len_new = LW'(cmd_q.tsize);
				res_d.status = ccs_pkg::ST_WRITTEN;
			end
			default: res_d.status = ccs_pkg::ST_ACK;
		endcase
		if (cmd_q.kind != ccs_pkg::KIND_OUT_OF_RANGE)
			res_d.next_target = 3'(ring_new);
		res_d.skip_word = 16'(skip_next) & ccs_pkg::SKIP_MASK;
	end

	// per-path control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PATHS; i++) begin
				length_q[i]   <= LW'(1);
				position_q[i] <= '0;
				ring_q[i]     <= '0;
			end
			row_valid_q <= '0;
			skip_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				skip_q <= skip_next;
				if (len_we)
					length_q[p] <= len_new;
				if (pos_we)
					position_q[p] <= nxt_q;
				if (ring_we)
					ring_q[p] <= ring_new;
				if (lock_we)
					row_valid_q[p] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (exec)
			res_q <= res_d;
	end

	// lock row memory
	always_ff @(posedge clk) begin
		if (exec && lock_we)
			lock_mem[p] <= lock_wdata;
		if (state_q == ccs_pkg::BK_LOOKUP)
			lock_row_q <= lock_mem[p];
	end

	// channel table memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (exec && chan_we)
			chan_mem[{p, TIW'(cmd_q.tslot)}] <= cmd_q.tval;
		if (state_q == ccs_pkg::BK_LOOKUP) begin
			rd_cur_q <= chan_mem[{p, position_q[p]}];
			rd_nxt_q <= chan_mem[{p, nxt_q}];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> dv/capture_channel_sequencer_test.sv
// self-checking testbench of capture_channel_sequencer: directed and random items
// checked against an in-bench model of tables, buffer rings and skip bits
// depends on ccs_pkg and the capture_channel_sequencer rtl
module capture_channel_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE_WAIT = 16;

	// one input item as seen on the ports
	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] path;
		logic       even;
		logic       loss;
		logic [2:0] bslot;
		logic [3:0] tslot;
		logic [7:0] tval;
		logic [4:0] tsize;
	} capture_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [3:0]  path;
	logic        field_even;
	logic        video_loss;
	logic [2:0]  buffer_slot;
	logic [3:0]  table_slot;
	logic [7:0]  table_value;
	logic [4:0]  table_size;
	logic        cfg_write;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        done;
	logic [2:0]  status;
	logic [2:0]  filled_buffer;
	logic [2:0]  next_target;
	logic [7:0]  captured_channel;
	logic        field_flag;
	logic        loss_flag;
	logic [15:0] skip_word;
	logic        advanced;
	logic        notify;

	// model state
	logic [7:0]  chan_tbl [16][16];
	logic [4:0]  tbl_len [16];
	logic [3:0]  tbl_pos [16];
	logic [2:0]  ring_idx [16];
	logic [7:0]  lock_rows [16];
	logic [15:0] skip_bits_m;
	logic [15:0] enable_mask_m;
	logic [7:0]  invalid_m;

	ccs_pkg::res_t expected_results[$];
	int   error_count = 0;
	int   idle_cycles = 0;
	bit   gaps_on = 1'b1;

	capture_channel_sequencer u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .path(path), .field_even(field_even), .video_loss(video_loss),
		.buffer_slot(buffer_slot), .table_slot(table_slot), .table_value(table_value),
		.table_size(table_size), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .status(status), .filled_buffer(filled_buffer),
		.next_target(next_target), .captured_channel(captured_channel),
		.field_flag(field_flag), .loss_flag(loss_flag), .skip_word(skip_word),
		.advanced(advanced), .notify(notify)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// reset state of the model
	task automatic reset_model();
		int p;
		int s;
		for (p = 0; p < 16; p++) begin
			for (s = 0; s < 16; s++)
				chan_tbl[p][s] = 8'd0;
			tbl_len[p] = 5'd1;
			tbl_pos[p] = 4'd0;
			ring_idx[p] = 3'd0;
			lock_rows[p] = 8'd0;
		end
		skip_bits_m = 16'd0;
		enable_mask_m = 16'd0;
		invalid_m = ccs_pkg::INVALID_RESET;
	endtask

	// expected result of one item, updates the model state; 0 when no result
	function automatic bit predict_result(input capture_item_t it,
		output ccs_pkg::res_t r);
		int pos;
		int len;
		logic [2:0] idx;
		logic [7:0] nxt;
		logic quiet;
		r = '0;
		r.status = ccs_pkg::ST_ACK;
		if (it.mode == ccs_pkg::MODE_UNUSED)
			return 1'b0;
		case (it.mode)
			ccs_pkg::MODE_CAPTURE: begin
				if (enable_mask_m[it.path]) begin
					pos = int'(tbl_pos[it.path]);
					r.captured_channel = chan_tbl[it.path][pos];
					r.field_flag = it.even;
					r.loss_flag = it.loss;
					quiet = (r.captured_channel == invalid_m) ||
						(!it.loss && skip_bits_m[it.path]);
					if (quiet) begin
						r.status = ccs_pkg::ST_QUIET;
					end else begin
						idx = ring_idx[it.path];
						if (!lock_rows[it.path][idx]) begin
							lock_rows[it.path][idx] = 1'b1;
							r.filled_buffer = idx;
							ring_idx[it.path] = idx + 3'd1;
							r.status = ccs_pkg::ST_CAPTURED;
							r.notify = 1'b1;
						end else begin
							r.status = ccs_pkg::ST_BUSY;
						end
					end
					// even field moves the table on and rearms the skip bit
					if (it.even) begin
						len = int'(tbl_len[it.path]);
						if (len == 0 || len > 16)
							len = 1;
						pos = (pos + 1) % len;
						nxt = chan_tbl[it.path][pos];
						skip_bits_m[it.path] = (nxt == invalid_m) || it.loss;
						tbl_pos[it.path] = 4'(pos);
						r.advanced = 1'b1;
					end
				end
			end
			ccs_pkg::MODE_RELEASE: begin
				lock_rows[it.path][it.bslot] = 1'b0;
				r.status = ccs_pkg::ST_RELEASED;
			end
			default: begin
				chan_tbl[it.path][it.tslot] = it.tval;
				len = int'(it.tsize);
				if (len < 1)
					len = 1;
				if (len > 16)
					len = 16;
				tbl_len[it.path] = 5'(len);
				r.status = ccs_pkg::ST_WRITTEN;
			end
		endcase
		r.next_target = ring_idx[it.path];
		r.skip_word = skip_bits_m & ccs_pkg::SKIP_MASK;
		return 1'b1;
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// result check, register writes and item prediction, all sampled at the edge
	always @(posedge clk) begin
		ccs_pkg::res_t want;
		ccs_pkg::res_t got;
		capture_item_t cur;
		if (!arst_n) begin
			reset_model();
		end else begin
			if (done) begin
				got = '{status, filled_buffer, next_target, captured_channel, field_flag,
					loss_flag, skip_word, advanced, notify};
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, status %0d", $time, status);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 16'(want.status), 16'(got.status));
					compare_field("filled_buffer", 16'(want.filled_buffer),
						16'(got.filled_buffer));
					compare_field("next_target", 16'(want.next_target),
						16'(got.next_target));
					compare_field("captured_channel", 16'(want.captured_channel),
						16'(got.captured_channel));
					compare_field("field_flag", 16'(want.field_flag), 16'(got.field_flag));
					compare_field("loss_flag", 16'(want.loss_flag), 16'(got.loss_flag));
					compare_field("skip_word", want.skip_word, got.skip_word);
					compare_field("advanced", 16'(want.advanced), 16'(got.advanced));
					compare_field("notify", 16'(want.notify), 16'(got.notify));
				end
			end
			if (cfg_write) begin
				if (cfg_index == ccs_pkg::CFG_ENABLE_MASK)
					enable_mask_m = cfg_data;
				else
					invalid_m = cfg_data[7:0];
			end
			if (start && !busy) begin
				cur = '{mode, path, field_even, video_loss, buffer_slot, table_slot,
					table_value, table_size};
				if (predict_result(cur, want))
					expected_results.push_back(want);
			end
			if (done || cfg_write || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// watchdog on cycles with no traffic at all
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	// send one item, keeps start high so back-to-back items need no extra edge
	task automatic send_item(input logic [1:0] m, input logic [3:0] p, input logic ev,
		input logic lo, input logic [2:0] bs, input logic [3:0] ts, input logic [7:0] tv,
		input logic [4:0] sz);
		if (gaps_on && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		path <= p;
		field_even <= ev;
		video_loss <= lo;
		buffer_slot <= bs;
		table_slot <= ts;
		table_value <= tv;
		table_size <= sz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending and wait for every expected result, then some spare cycles
	task automatic drain_results(input int extra_cycles);
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// a release slot, mostly one that is locked so the ring keeps moving
	function automatic logic [2:0] release_slot_for(input logic [3:0] p);
		logic [2:0] s;
		int k;
		s = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 99) < 70)
			for (k = 0; k < 8; k++)
				if (lock_rows[p][3'(s + k)])
					return 3'(s + k);
		return s;
	endfunction

	// defaults after reset: all paths masked, size saturation, unused mode
	task automatic test_reset_behavior();
		send_item(ccs_pkg::MODE_CAPTURE, 4'd15, 1'b1, 1'b1, 3'd7, 4'd15, 8'hFF, 5'd31);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'h00, 5'd0);
		send_item(ccs_pkg::MODE_UNUSED, 4'd5, 1'b1, 1'b0, 3'd2, 4'd3, 8'h5A, 5'd4);
		send_item(ccs_pkg::MODE_RELEASE, 4'd3, 1'b0, 1'b0, 3'd7, 4'd0, 8'h00, 5'd1);
		send_item(ccs_pkg::MODE_TABLE, 4'd15, 1'b0, 1'b0, 3'd0, 4'd15, 8'h00, 5'd0);
		send_item(ccs_pkg::MODE_TABLE, 4'd15, 1'b0, 1'b0, 3'd0, 4'd14, 8'hFF, 5'd31);
		send_item(ccs_pkg::MODE_TABLE, 4'd15, 1'b0, 1'b0, 3'd0, 4'd13, 8'h80, 5'd17);
		send_item(ccs_pkg::MODE_TABLE, 4'd15, 1'b0, 1'b0, 3'd0, 4'd12, 8'h01, 5'd16);
	endtask

	// write every table entry so later lookups only see written entries
	task automatic test_table_fill();
		int p;
		int s;
		int pick;
		logic [7:0] tv;
		for (p = 0; p < 16; p++)
			for (s = 0; s < 16; s++) begin
				pick = $urandom_range(0, 99);
				tv = (pick < 20) ? ccs_pkg::INVALID_RESET : (pick < 25) ? 8'h00 :
					8'($urandom);
				send_item(ccs_pkg::MODE_TABLE, 4'(p), 1'($urandom), 1'($urandom),
					3'($urandom), 4'(s), tv, 5'($urandom_range(0, 31)));
			end
	endtask

	// directed capture walk on path 0: valid, invalid, skip, loss, full ring
	task automatic test_capture_sequence();
		int k;
		drain_results(SETTLE_WAIT);
		write_reg(ccs_pkg::CFG_ENABLE_MASK, 16'hFFFF);
		write_reg(ccs_pkg::CFG_INVALID_CHANNEL, 16'h00FF);
		send_item(ccs_pkg::MODE_TABLE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'd7, 5'd2);
		send_item(ccs_pkg::MODE_TABLE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd1, 8'hFF, 5'd2);
		// odd field, then even into an invalid slot, then back
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b1, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b1, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b1, 1'b1, 3'd0, 4'd0, 8'd0, 5'd0);
		// skip pending with a valid channel, with and without video loss
		send_item(ccs_pkg::MODE_TABLE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd1, 8'd9, 5'd2);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b0, 1'b1, 3'd0, 4'd0, 8'd0, 5'd0);
		// fill the ring, the last one finds its buffer locked
		for (k = 0; k < 5; k++)
			send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b0, 1'b1, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_RELEASE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_RELEASE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b0, 1'b1, 3'd0, 4'd0, 8'd0, 5'd0);
		// position beyond a table that was shortened
		send_item(ccs_pkg::MODE_TABLE, 4'd0, 1'b0, 1'b0, 3'd0, 4'd0, 8'd7, 5'd1);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd0, 1'b1, 1'b0, 3'd0, 4'd0, 8'd0, 5'd0);
		send_item(ccs_pkg::MODE_CAPTURE, 4'd15, 1'b1, 1'b1, 3'd7, 4'd15, 8'hFF, 5'd31);
	endtask

	// random items under one register setting, mostly on a few neighboring paths
	task automatic test_random_phase(input logic [15:0] mask_v, input logic [15:0] inv_v,
		input int n_items, input bit gaps, input bit pause_mid);
		int base;
		int sent;
		int pick;
		logic [3:0] p;
		logic [7:0] tv;
		logic [4:0] sz;
		drain_results(SETTLE_WAIT);
		write_reg(ccs_pkg::CFG_ENABLE_MASK, mask_v);
		write_reg(ccs_pkg::CFG_INVALID_CHANNEL, inv_v);
		gaps_on = gaps;
		base = $urandom_range(0, 15);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 70)
				p = 4'(base + $urandom_range(0, 3));
			else
				p = 4'($urandom_range(0, 15));
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(ccs_pkg::MODE_UNUSED, p, 1'($urandom), 1'($urandom),
					3'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
				continue;
			end
			if (pick < 55) begin
				send_item(ccs_pkg::MODE_CAPTURE, p, 1'($urandom),
					$urandom_range(0, 99) < 25, 3'($urandom), 4'($urandom),
					8'($urandom), 5'($urandom));
			end else if (pick < 78) begin
				send_item(ccs_pkg::MODE_RELEASE, p, 1'($urandom), 1'($urandom),
					release_slot_for(p), 4'($urandom), 8'($urandom), 5'($urandom));
			end else begin
				tv = ($urandom_range(0, 99) < 25) ? invalid_m : 8'($urandom);
				sz = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(1, 16)) :
					5'($urandom_range(0, 31));
				send_item(ccs_pkg::MODE_TABLE, p, 1'($urandom), 1'($urandom),
					3'($urandom), 4'($urandom), tv, sz);
			end
			sent++;
			// hold the sender until the block has fully drained
			if (pause_mid && sent == n_items / 2)
				drain_results(0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= ccs_pkg::MODE_CAPTURE;
		path <= 4'd0;
		field_even <= 1'b0;
		video_loss <= 1'b0;
		buffer_slot <= 3'd0;
		table_slot <= 4'd0;
		table_value <= 8'd0;
		table_size <= 5'd1;
		cfg_write <= 1'b0;
		cfg_index <= ccs_pkg::CFG_ENABLE_MASK;
		cfg_data <= 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_behavior();
		test_table_fill();
		test_capture_sequence();
		test_random_phase(16'hFFFF, 16'h00FF, 220, 1'b0, 1'b0);
		test_random_phase(16'($urandom), 16'h0000, 220, 1'b1, 1'b1);
		test_random_phase(16'h0000, 16'($urandom), 150, 1'b1, 1'b0);
		test_random_phase(16'($urandom), 16'($urandom), 220, 1'b1, 1'b0);
		test_random_phase(16'hFFFF, 16'hFF00 | 16'($urandom_range(0, 255)), 220, 1'b1,
			1'b0);

		drain_results(SETTLE_WAIT);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
